FILE: design/sacs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacs_pkg
// Shared types and constants for the spatial autocorrelation scorer.
// ----------------------------------------------------------------------------
package sacs_pkg;

   localparam int unsigned SACS_MAX_SPOTS = 1024;
   localparam int unsigned SACS_MAX_EDGES = 8192;

   localparam int unsigned SPOT_IDX_W = 10;
   localparam int unsigned Q_W        = 32;
   localparam int unsigned DIFF_W     = Q_W + 1;
   localparam int unsigned PROD_W     = 2 * DIFF_W;
   localparam int unsigned WIDE_W     = 128;
   localparam int unsigned WIDE_CNT_W = $clog2(WIDE_W);
   localparam int unsigned FRAC_BITS  = 16;
   localparam int unsigned MIN_FINITE = 3;

   localparam logic [Q_W-1:0]    SAT_POS   = 32'h7fff_ffff;
   localparam logic [Q_W-1:0]    SAT_NEG   = 32'h8000_0000;
   localparam logic [Q_W-1:0]    ONE_Q16   = 32'h0001_0000;
   localparam logic [WIDE_W-1:0] SCORE_LIM = 128'h8001_0000;

   typedef enum logic [1:0] {
      CMD_LOAD_VALUE = 2'd0,
      CMD_LOAD_EDGE  = 2'd1,
      CMD_COMPUTE    = 2'd2,
      CMD_CLEAR      = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FEW       = 3'd1,
      ST_ZERO_VAR  = 3'd2,
      ST_NO_EDGE   = 3'd3,
      ST_BAD_EDGE  = 3'd4,
      ST_OVERFLOW  = 3'd5
   } status_type;

   typedef enum logic {
      METHOD_MORAN = 1'b0,
      METHOD_GEARY = 1'b1
   } method_type;

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_DIV = 1'b1
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_sts_type;

   typedef struct packed {
      logic [1:0]            command;
      logic signed [Q_W-1:0] value;
      logic                  value_finite;
      logic [SPOT_IDX_W-1:0] edge_source;
      logic [SPOT_IDX_W-1:0] edge_target;
   } req_payload_type;

   typedef struct packed {
      logic signed [Q_W-1:0] statistic;
      logic signed [Q_W-1:0] score;
      logic [2:0]            status;
   } rsp_payload_type;

   typedef struct packed {
      logic                  finite;
      logic signed [Q_W-1:0] value;
   } spot_entry_type;

   typedef struct packed {
      logic [SPOT_IDX_W-1:0] src;
      logic [SPOT_IDX_W-1:0] tgt;
   } edge_entry_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CHK_RD, S_CHK, S_SUM_RD, S_SUM, S_MEAN, S_MEAN_W,
      S_SS_RD, S_SS_OPS, S_SS_MUL, S_SS_ACC, S_SS_END,
      S_NUM_RD, S_NUM_VRD, S_NUM_OPS, S_NUM_MUL, S_NUM_ACC, S_NUM_END,
      S_TOP, S_TOP_W, S_BOT, S_BOT_W, S_DIV_W, S_OUT
   } state_type;

endpackage

FILE: design/spatial_autocorrelation_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_autocorrelation_score
// Moran's I / Geary's C over loaded spot values and neighbor edges, Q16.16.
// ----------------------------------------------------------------------------
//  channel  ports                      direction  transfer when
//  req      req_valid/ready/payload    in         req_valid & req_ready
//  rsp      rsp_valid/ready/payload    out        rsp_valid & rsp_ready
//  csr      csr_wr_en/csr_wr_data      in         csr_wr_en
//
// Load value, load edge and clear complete in the idle state as the
// request is taken. Compute walks the edges twice and the spots twice
// through the memory read ports and the multiplier, and uses the shared
// shift-add / divide unit for the mean and for the final quotient.
// req_ready is low for the whole compute. A finished result waits in the
// output register; a compute whose result finds it still full stalls at the
// end. Reset is synchronous and clears the counts; the stores need no clear.
// ----------------------------------------------------------------------------
module spatial_autocorrelation_score
   import sacs_pkg::*;
#(
   parameter int unsigned MAX_SPOTS = SACS_MAX_SPOTS,
   parameter int unsigned MAX_EDGES = SACS_MAX_EDGES
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

   localparam int unsigned SPOT_CNT_W = $clog2(MAX_SPOTS + 1);
   localparam int unsigned EDGE_CNT_W = $clog2(MAX_EDGES + 1);
   localparam int unsigned SPOT_AW    = (MAX_SPOTS > 1) ? $clog2(MAX_SPOTS) : 1;
   localparam int unsigned EDGE_AW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int unsigned IDX_W      = (SPOT_CNT_W > EDGE_CNT_W) ? SPOT_CNT_W : EDGE_CNT_W;
   localparam int unsigned SUM_W      = Q_W + SPOT_CNT_W;
   localparam int unsigned DEN_W      = PROD_W + SPOT_CNT_W;
   localparam int unsigned NUM_W      = PROD_W + 1 + EDGE_CNT_W;

   spot_entry_type spot_mem [MAX_SPOTS];
   edge_entry_type edge_mem [MAX_EDGES];

   state_type                 state_ff, state_in;
   logic [SPOT_CNT_W-1:0]     spot_cnt_ff, spot_cnt_in;
   logic [EDGE_CNT_W-1:0]     edge_cnt_ff, edge_cnt_in;
   logic                      ovf_ff, ovf_in;
   method_type                method_ff;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [IDX_W-1:0]          idx_nxt;
   logic [SPOT_CNT_W-1:0]     n_ff, n_in;
   logic [EDGE_CNT_W-1:0]     w_ff, w_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [SUM_W-1:0]   sum_mag;
   logic signed [DIFF_W-1:0]  mean_ff, mean_in;
   logic signed [DEN_W-1:0]   den_ff, den_in;
   logic signed [NUM_W-1:0]   num_ff, num_in;
   logic signed [NUM_W-1:0]   num_mag;
   logic signed [DIFF_W-1:0]  op_a_ff, op_a_in;
   logic signed [DIFF_W-1:0]  op_b_ff, op_b_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [WIDE_W-1:0]         top_ff, top_in;
   logic                      neg_ff, neg_in;
   status_type                status_ff, status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_ff, rsp_in;

   logic                      spot_we, edge_we;
   logic [SPOT_AW-1:0]        spot_ra;
   spot_entry_type            va_rd_ff, vb_rd_ff;
   edge_entry_type            edge_rd_ff;
   logic                      last_spot, last_edge;
   logic signed [DIFF_W-1:0]  va_ext, vb_ext;

   arith_ctl_type             arith_ctl;
   arith_sts_type             arith_sts;
   logic [WIDE_W-1:0]         arith_a, arith_b, arith_res;
   logic [Q_W-1:0]            stat_val, score_val;

   sacs_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .ctl    (arith_ctl),
      .opa    (arith_a),
      .opb    (arith_b),
      .sts    (arith_sts),
      .result (arith_res)
   );

   // storage
   always_ff @(posedge clock) begin
      if (spot_we) begin
         spot_mem[spot_cnt_ff[SPOT_AW-1:0]] <= {req_payload.value_finite, req_payload.value};
      end
      if (edge_we) begin
         edge_mem[edge_cnt_ff[EDGE_AW-1:0]] <= {req_payload.edge_source, req_payload.edge_target};
      end
      va_rd_ff   <= spot_mem[spot_ra];
      vb_rd_ff   <= spot_mem[SPOT_AW'(edge_rd_ff.tgt)];
      edge_rd_ff <= edge_mem[idx_ff[EDGE_AW-1:0]];
   end

   assign spot_ra   = (state_ff == S_NUM_VRD) ? SPOT_AW'(edge_rd_ff.src) : idx_ff[SPOT_AW-1:0];
   assign idx_nxt   = idx_ff + 1'b1;
   assign last_spot = (idx_nxt == IDX_W'(spot_cnt_ff));
   assign last_edge = (idx_nxt == IDX_W'(edge_cnt_ff));
   assign va_ext    = DIFF_W'(va_rd_ff.value);
   assign vb_ext    = DIFF_W'(vb_rd_ff.value);
   assign sum_mag   = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
   assign num_mag   = num_ff[NUM_W-1] ? -num_ff : num_ff;

   // final saturation from the quotient
   always_comb begin
      if (!neg_ff) begin
         stat_val = (arith_res > WIDE_W'(SAT_POS)) ? SAT_POS : arith_res[Q_W-1:0];
      end else begin
         stat_val = (arith_res > WIDE_W'(SAT_NEG)) ? SAT_NEG : Q_W'(-arith_res[Q_W-1:0]);
      end
      if (method_ff == METHOD_GEARY) begin
         score_val = (arith_res > SCORE_LIM) ? SAT_NEG : Q_W'(ONE_Q16 - arith_res[Q_W-1:0]);
      end else begin
         score_val = stat_val;
      end
   end

   always_comb begin
      state_in     = state_ff;
      spot_cnt_in  = spot_cnt_ff;
      edge_cnt_in  = edge_cnt_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      w_in         = w_ff;
      sum_in       = sum_ff;
      mean_in      = mean_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      prod_in      = prod_ff;
      top_in       = top_ff;
      neg_in       = neg_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      spot_we      = 1'b0;
      edge_we      = 1'b0;
      arith_ctl    = '{start: 1'b0, op: OP_MUL};
      arith_a      = '0;
      arith_b      = '0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_payload.command)
                  CMD_LOAD_VALUE: begin
                     if (spot_cnt_ff < SPOT_CNT_W'(MAX_SPOTS)) begin
                        spot_we     = 1'b1;
                        spot_cnt_in = spot_cnt_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  CMD_LOAD_EDGE: begin
                     if (edge_cnt_ff < EDGE_CNT_W'(MAX_EDGES)) begin
                        edge_we     = 1'b1;
                        edge_cnt_in = edge_cnt_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     spot_cnt_in = '0;
                     edge_cnt_in = '0;
                     ovf_in      = 1'b0;
                  end
                  default: begin
                     idx_in = '0;
                     n_in   = '0;
                     w_in   = '0;
                     sum_in = '0;
                     den_in = '0;
                     num_in = '0;
                     if (ovf_ff) begin
                        status_in = ST_OVERFLOW;
                        state_in  = S_OUT;
                     end else if (edge_cnt_ff != '0) begin
                        state_in = S_CHK_RD;
                     end else if (spot_cnt_ff != '0) begin
                        state_in = S_SUM_RD;
                     end else begin
                        state_in = S_MEAN;
                     end
                  end
               endcase
            end
         end
         S_CHK_RD: state_in = S_CHK;
         S_CHK: begin
            if (IDX_W'(edge_rd_ff.src) >= IDX_W'(spot_cnt_ff) ||
                IDX_W'(edge_rd_ff.tgt) >= IDX_W'(spot_cnt_ff)) begin
               status_in = ST_BAD_EDGE;
               state_in  = S_OUT;
            end else if (last_edge) begin
               idx_in   = '0;
               state_in = (spot_cnt_ff != '0) ? S_SUM_RD : S_MEAN;
            end else begin
               idx_in   = idx_nxt;
               state_in = S_CHK_RD;
            end
         end
         S_SUM_RD: state_in = S_SUM;
         S_SUM: begin
            if (va_rd_ff.finite) begin
               n_in   = n_ff + 1'b1;
               sum_in = sum_ff + SUM_W'(va_rd_ff.value);
            end
            idx_in   = last_spot ? '0 : idx_nxt;
            state_in = last_spot ? S_MEAN : S_SUM_RD;
         end
         S_MEAN: begin
            if (n_ff < SPOT_CNT_W'(MIN_FINITE)) begin
               status_in = ST_FEW;
               state_in  = S_OUT;
            end else begin
               // round to nearest, ties away from zero, on the magnitude
               arith_ctl = '{start: 1'b1, op: OP_DIV};
               arith_a   = WIDE_W'($unsigned(sum_mag)) + WIDE_W'(n_ff >> 1);
               arith_b   = WIDE_W'(n_ff);
               state_in  = S_MEAN_W;
            end
         end
         S_MEAN_W: begin
            if (arith_sts.done) begin
               mean_in  = sum_ff[SUM_W-1] ? -$signed(DIFF_W'(arith_res))
                                          : $signed(DIFF_W'(arith_res));
               idx_in   = '0;
               state_in = S_SS_RD;
            end
         end
         S_SS_RD: state_in = S_SS_OPS;
         S_SS_OPS: begin
            if (va_rd_ff.finite) begin
               op_a_in  = va_ext - mean_ff;
               op_b_in  = va_ext - mean_ff;
               state_in = S_SS_MUL;
            end else begin
               idx_in   = last_spot ? '0 : idx_nxt;
               state_in = last_spot ? S_SS_END : S_SS_RD;
            end
         end
         S_SS_MUL: begin
            prod_in  = op_a_ff * op_b_ff;
            state_in = S_SS_ACC;
         end
         S_SS_ACC: begin
            den_in   = den_ff + DEN_W'(prod_ff);
            idx_in   = last_spot ? '0 : idx_nxt;
            state_in = last_spot ? S_SS_END : S_SS_RD;
         end
         S_SS_END: begin
            idx_in = '0;
            if (den_ff == '0) begin
               status_in = ST_ZERO_VAR;
               state_in  = S_OUT;
            end else if (edge_cnt_ff == '0) begin
               status_in = ST_NO_EDGE;
               state_in  = S_OUT;
            end else begin
               state_in = S_NUM_RD;
            end
         end
         S_NUM_RD:  state_in = S_NUM_VRD;
         S_NUM_VRD: state_in = S_NUM_OPS;
         S_NUM_OPS: begin
            if (va_rd_ff.finite && vb_rd_ff.finite) begin
               w_in = w_ff + 1'b1;
               if (method_ff == METHOD_GEARY) begin
                  op_a_in = va_ext - vb_ext;
                  op_b_in = va_ext - vb_ext;
               end else begin
                  op_a_in = va_ext - mean_ff;
                  op_b_in = vb_ext - mean_ff;
               end
               state_in = S_NUM_MUL;
            end else begin
               idx_in   = last_edge ? '0 : idx_nxt;
               state_in = last_edge ? S_NUM_END : S_NUM_RD;
            end
         end
         S_NUM_MUL: begin
            prod_in  = op_a_ff * op_b_ff;
            state_in = S_NUM_ACC;
         end
         S_NUM_ACC: begin
            num_in   = num_ff + NUM_W'(prod_ff);
            idx_in   = last_edge ? '0 : idx_nxt;
            state_in = last_edge ? S_NUM_END : S_NUM_RD;
         end
         S_NUM_END: begin
            if (w_ff == '0) begin
               status_in = ST_NO_EDGE;
               state_in  = S_OUT;
            end else begin
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            neg_in    = num_ff[NUM_W-1];
            arith_ctl = '{start: 1'b1, op: OP_MUL};
            arith_a   = WIDE_W'($unsigned(num_mag));
            arith_b   = (method_ff == METHOD_GEARY) ? WIDE_W'(n_ff) - 1'b1 : WIDE_W'(n_ff);
            state_in  = S_TOP_W;
         end
         S_TOP_W: begin
            if (arith_sts.done) begin
               top_in   = arith_res << FRAC_BITS;
               state_in = S_BOT;
            end
         end
         S_BOT: begin
            arith_ctl = '{start: 1'b1, op: OP_MUL};
            arith_a   = WIDE_W'($unsigned(den_ff));
            arith_b   = (method_ff == METHOD_GEARY) ? WIDE_W'(w_ff) << 1 : WIDE_W'(w_ff);
            state_in  = S_BOT_W;
         end
         S_BOT_W: begin
            // divider starts on the cycle the product lands
            if (arith_sts.done) begin
               arith_ctl = '{start: 1'b1, op: OP_DIV};
               arith_a   = top_ff;
               arith_b   = arith_res;
               state_in  = S_DIV_W;
            end
         end
         S_DIV_W: begin
            if (arith_sts.done) begin
               status_in = ST_OK;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = status_ff;
               if (status_ff == ST_OK) begin
                  rsp_in.statistic = stat_val;
                  rsp_in.score     = score_val;
               end else begin
                  rsp_in.statistic = '0;
                  rsp_in.score     = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         spot_cnt_ff  <= '0;
         edge_cnt_ff  <= '0;
         ovf_ff       <= 1'b0;
         method_ff    <= METHOD_MORAN;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_OK;
      end else begin
         state_ff     <= state_in;
         spot_cnt_ff  <= spot_cnt_in;
         edge_cnt_ff  <= edge_cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         if (csr_wr_en) method_ff <= method_type'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      n_ff    <= n_in;
      w_ff    <= w_in;
      sum_ff  <= sum_in;
      mean_ff <= mean_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      op_a_ff <= op_a_in;
      op_b_ff <= op_b_in;
      prod_ff <= prod_in;
      top_ff  <= top_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: design/sacs_arith.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacs_arith
// Shared 128-bit shift-add multiplier and restoring divider, one bit a cycle.
// ----------------------------------------------------------------------------
module sacs_arith
   import sacs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  arith_ctl_type       ctl,
   input  logic [WIDE_W-1:0]   opa,
   input  logic [WIDE_W-1:0]   opb,
   output arith_sts_type       sts,
   output logic [WIDE_W-1:0]   result
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   arith_op_type          op_ff, op_in;
   logic [WIDE_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDE_W-1:0]     a_ff, a_in;
   logic [WIDE_W-1:0]     b_ff, b_in;
   logic [WIDE_W-1:0]     acc_ff, acc_in;
   logic [WIDE_W:0]       rem_shift;
   logic                  ge;

   // a holds multiplicand or dividend/quotient, b multiplier or divisor,
   // acc the product or the partial remainder
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      rem_shift = {acc_ff, a_ff[WIDE_W-1]};
      ge        = (rem_shift >= {1'b0, b_ff});
      if (!busy_ff && ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         cnt_in  = '0;
         a_in    = opa;
         b_in    = opb;
         acc_in  = '0;
      end else if (busy_ff) begin
         case (op_ff)
            OP_MUL: begin
               if (b_ff == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  if (b_ff[0]) acc_in = acc_ff + a_ff;
                  a_in = a_ff << 1;
                  b_in = b_ff >> 1;
               end
            end
            OP_DIV: begin
               acc_in = ge ? WIDE_W'(rem_shift - {1'b0, b_ff}) : rem_shift[WIDE_W-1:0];
               a_in   = {a_ff[WIDE_W-2:0], ge};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == WIDE_CNT_W'(WIDE_W - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = (op_ff == OP_DIV) ? a_ff : acc_ff;

endmodule
